/* rtl/i2c_master_byte_engine_macros.svh */
// Assertion helpers used by the byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/i2cm_pkg.sv */
`timescale 1ns / 1ps

package i2cm_pkg;

    // Command codes carried in the input tuser
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_CHECK = 3'd4;

    // Phase sequencer states
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_START     = 3'd1,
        ST_STOP      = 3'd2,
        ST_WRITE     = 3'd3,
        ST_READ_REL  = 3'd4,
        ST_READ_BITS = 3'd5,
        ST_READ_ACK  = 3'd6,
        ST_CHECK     = 3'd7
    } t_state;

    // Controls from the sequencer to the bit shifter
    typedef struct packed {
        logic load;    // capture a new command's bytes
        logic tx_adv;  // move to the next transmit bit
        logic rx_adv;  // sample one received bit
    } t_shift_ctl;

endpackage

/* rtl/i2cm_shift.sv */
`timescale 1ns / 1ps

module i2cm_shift (
    input  logic                  i_clk,
    input  i2cm_pkg::t_shift_ctl  i_ctl,
    input  logic [7:0]            i_write_data,
    input  logic [7:0]            i_line_bits,
    output logic                  o_tx_bit,
    output logic [7:0]            o_rx_byte
);
    import i2cm_pkg::*;

    logic [7:0] r_tx;
    logic [7:0] r_line;
    logic [7:0] r_rx;

    // Load on a new command, then move one bit per step, MSB first
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_tx   <= i_write_data;
            r_line <= i_line_bits;
            r_rx   <= 8'h00;
        end else begin
            if (i_ctl.tx_adv) begin
                r_tx <= {r_tx[6:0], 1'b0};
            end
            if (i_ctl.rx_adv) begin
                r_rx   <= {r_rx[6:0], r_line[7]};
                r_line <= {r_line[6:0], 1'b0};
            end
        end
    end

    assign o_tx_bit  = r_tx[7];
    assign o_rx_byte = r_rx;

endmodule

/* rtl/i2c_master_byte_engine.sv */
// I2C master byte engine: takes one command word (start, stop, write byte,
// read byte with ACK, check ACK) and emits the pin phases it drives, one
// output word per phase, each showing SCL, the SDA latch and the SDA drive
// enable after that change; tlast marks a command's final phase. Commands
// emit 4 (start, stop), 24 (write), 22 (read) and 5 (check) phases, one per
// cycle when the output side takes a word every cycle, and the command word
// is taken before the first phase. The phase sequencer makes one phase per
// cycle unless the output register is stalled, and the bytes move through
// shift registers one bit per SCL pulse. A new command is taken once the
// previous one has issued its last phase; undefined command codes are taken
// and dropped without output.
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_macros.svh"

module i2c_master_byte_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] write_data, [15:8] line_bits, [16] line_ack, [23:17] zero
    input  logic [23:0] s_axis_tdata,
    // [2:0] command
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] sda_enable, [10:3] read_data,
    // [11] ack_seen, [15:12] zero
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import i2cm_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_sub, n_sub;
    logic [2:0] r_bit, n_bit;
    logic       r_scl, r_sda, r_drv;
    logic       r_ack;

    logic       r_ov;
    logic       r_o_scl, r_o_sda, r_o_drv, r_o_ack, r_o_last;
    logic [7:0] r_o_rd;

    logic       accept, fire;
    logic       ph_scl, ph_sda, ph_drv, ph_last, ph_rd_en, ph_ack_en;
    t_shift_ctl shift_ctl;
    logic       tx_bit;
    logic [7:0] rx_byte;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fire          = (r_state != ST_IDLE) && (!r_ov || m_axis_tready);

    i2cm_shift u_shift (
        .i_clk        (i_clk),
        .i_ctl        (shift_ctl),
        .i_write_data (s_axis_tdata[7:0]),
        .i_line_bits  (s_axis_tdata[15:8]),
        .o_tx_bit     (tx_bit),
        .o_rx_byte    (rx_byte)
    );

    // Next state and phase counters
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_sub   = r_sub;
        n_bit   = r_bit;
        if (r_state == ST_IDLE) begin
            n_step = 3'd0;
            n_sub  = 2'd0;
            n_bit  = 3'd0;
            if (accept) begin
                unique case (s_axis_tuser)
                    CMD_START: n_state = ST_START;
                    CMD_STOP:  n_state = ST_STOP;
                    CMD_WRITE: n_state = ST_WRITE;
                    CMD_READ:  n_state = ST_READ_REL;
                    CMD_CHECK: n_state = ST_CHECK;
                    default:   n_state = ST_IDLE;
                endcase
            end
        end else if (fire) begin
            unique case (r_state)
                ST_START, ST_STOP: begin
                    n_step = r_step + 3'd1;
                    if (r_step == 3'd3) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_WRITE: begin
                    if (r_sub == 2'd2) begin
                        n_sub = 2'd0;
                        n_bit = r_bit + 3'd1;
                        if (r_bit == 3'd7) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
                ST_READ_REL: n_state = ST_READ_BITS;
                ST_READ_BITS: begin
                    if (r_sub == 2'd1) begin
                        n_sub = 2'd0;
                        n_bit = r_bit + 3'd1;
                        if (r_bit == 3'd7) begin
                            n_state = ST_READ_ACK;
                            n_step  = 3'd0;
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
                ST_READ_ACK, ST_CHECK: begin
                    n_step = r_step + 3'd1;
                    if (r_step == 3'd4) begin
                        n_state = ST_IDLE;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    // Pin change of the current phase
    always_comb begin
        ph_scl           = r_scl;
        ph_sda           = r_sda;
        ph_drv           = r_drv;
        ph_last          = 1'b0;
        ph_rd_en         = 1'b0;
        ph_ack_en        = 1'b0;
        shift_ctl.load   = accept;
        shift_ctl.tx_adv = 1'b0;
        shift_ctl.rx_adv = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_START, ST_STOP: begin
                unique case (r_step)
                    3'd0:    ph_sda = (r_state == ST_STOP) ? 1'b0 : 1'b1;
                    3'd1:    ph_scl = 1'b1;
                    3'd2:    ph_sda = (r_state == ST_STOP) ? 1'b1 : 1'b0;
                    default: begin
                        ph_scl  = 1'b0;
                        ph_last = 1'b1;
                    end
                endcase
            end
            ST_WRITE: begin
                unique case (r_sub)
                    2'd0:    ph_sda = tx_bit;
                    2'd1:    ph_scl = 1'b1;
                    default: begin
                        ph_scl           = 1'b0;
                        ph_last          = (r_bit == 3'd7);
                        shift_ctl.tx_adv = fire;
                    end
                endcase
            end
            ST_READ_REL: ph_drv = 1'b0;
            ST_READ_BITS: begin
                if (r_sub == 2'd0) begin
                    ph_scl = 1'b0;
                end else begin
                    ph_scl           = 1'b1;
                    shift_ctl.rx_adv = fire;
                end
            end
            ST_READ_ACK: begin
                unique case (r_step)
                    3'd0:    ph_drv = 1'b1;
                    3'd1:    ph_scl = 1'b0;
                    3'd2:    ph_sda = 1'b0;
                    3'd3:    ph_scl = 1'b1;
                    default: begin
                        ph_scl   = 1'b0;
                        ph_last  = 1'b1;
                        ph_rd_en = 1'b1;
                    end
                endcase
            end
            ST_CHECK: begin
                unique case (r_step)
                    3'd0:    ph_sda = 1'b1;
                    3'd1:    ph_scl = 1'b1;
                    3'd2:    ph_drv = 1'b0;
                    3'd3:    ph_drv = 1'b1;
                    default: begin
                        ph_scl    = 1'b0;
                        ph_last   = 1'b1;
                        ph_ack_en = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Sequencer and pin state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 3'd0;
            r_sub   <= 2'd0;
            r_bit   <= 3'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drv   <= 1'b1;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sub   <= n_sub;
            r_bit   <= n_bit;
            if (fire) begin
                r_scl <= ph_scl;
                r_sda <= ph_sda;
                r_drv <= ph_drv;
            end
        end
    end

    // Hold the sampled acknowledge for the check command
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ack <= s_axis_tdata[16];
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (fire) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_scl  <= ph_scl;
            r_o_sda  <= ph_sda;
            r_o_drv  <= ph_drv;
            r_o_rd   <= ph_rd_en ? rx_byte : 8'h00;
            r_o_ack  <= ph_ack_en ? r_ack : 1'b0;
            r_o_last <= ph_last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'h0, r_o_ack, r_o_rd, r_o_drv, r_o_sda, r_o_scl};
    assign m_axis_tlast  = r_o_last;

    `ASSERT_NEXT(a_last_ends_cmd, i_clk, i_rst_n, fire && ph_last, r_state == ST_IDLE, "sequencer kept running after the last phase")
    `ASSERT_NEXT(a_cmd_starts, i_clk, i_rst_n, accept && (s_axis_tuser <= CMD_CHECK), r_state != ST_IDLE, "valid command did not start")
    `ASSERT_IMPLY(a_mid_busy, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, r_state != ST_IDLE, "sequencer idle with a command unfinished")
    `ASSERT_IMPLY(a_mid_clean, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, (r_o_rd == 8'h00) && !r_o_ack, "read data or ack shown before the last phase")
    `ASSERT_IMPLY(a_idle_clock, i_clk, i_rst_n, (r_state == ST_IDLE) && !r_drv, 1'b0, "SDA left released between commands")

endmodule

/* test/tb_i2c_master_byte_engine.sv */
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
    import i2cm_pkg::*;

    // Codes the block takes and drops without output
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;
    localparam int NUM_CMDS_WANTED = 260;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] wdata;
        logic [7:0] line_bits;
        logic       line_ack;
        bit         drain;     // hold this command back until all phases are out
    } t_i2c_cmd;

    typedef struct {
        logic       scl;
        logic       sda;
        logic       sda_en;
        logic [7:0] rd_byte;
        logic       ack;
        logic       last;
    } t_pin_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [7:0] write_data, [15:8] line_bits, [16] line_ack, [23:17] zero
    logic [23:0] s_tdata = '0;
    // [2:0] command
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] scl_level, [1] sda_level, [2] sda_enable, [10:3] read_data,
    // [11] ack_seen, [15:12] zero
    logic [15:0] m_tdata;
    logic        m_tlast;

    t_i2c_cmd   cmd_q[$];
    t_pin_phase exp_phases[$];

    // Pin state tracked by the predictor
    logic scl_q = 1'b1;
    logic sda_q = 1'b1;
    logic drive_q = 1'b1;

    int  n_errors = 0;
    int  n_real_cmds = 0;
    int  n_phases_seen = 0;
    int  n_taken[8];
    bit  s_word_taken = 1'b0;
    int  gap_left = 0;
    int  burst_left = 4;
    int  rx_mode = 0;
    int  rx_mode_left = 100;
    int  rx_stall_left = 0;
    int  idle_cycles = 0;

    i2c_master_byte_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Queue a command; reserved codes do not count toward the total
    function automatic void add_cmd(logic [2:0] cmd, logic [7:0] wd, logic [7:0] lb,
                                    logic la, bit drain);
        t_i2c_cmd c;
        c.cmd = cmd;
        c.wdata = wd;
        c.line_bits = lb;
        c.line_ack = la;
        c.drain = drain;
        cmd_q.push_back(c);
        if (cmd <= CMD_CHECK)
            n_real_cmds++;
    endfunction

    // Record the pins as they stand after one phase
    function automatic void push_phase(logic [7:0] rd, logic ack, logic last);
        t_pin_phase p;
        p.scl = scl_q;
        p.sda = sda_q;
        p.sda_en = drive_q;
        p.rd_byte = rd;
        p.ack = ack;
        p.last = last;
        exp_phases.push_back(p);
    endfunction

    // Expand one command into its pin phases
    function automatic void predict_pin_phases(t_i2c_cmd c);
        logic [7:0] rx;
        rx = '0;
        case (c.cmd)
            CMD_START: begin
                sda_q = 1'b1;    push_phase('0, 1'b0, 1'b0);
                scl_q = 1'b1;    push_phase('0, 1'b0, 1'b0);
                sda_q = 1'b0;    push_phase('0, 1'b0, 1'b0);
                scl_q = 1'b0;    push_phase('0, 1'b0, 1'b1);
            end
            CMD_STOP: begin
                sda_q = 1'b0;    push_phase('0, 1'b0, 1'b0);
                scl_q = 1'b1;    push_phase('0, 1'b0, 1'b0);
                sda_q = 1'b1;    push_phase('0, 1'b0, 1'b0);
                scl_q = 1'b0;    push_phase('0, 1'b0, 1'b1);
            end
            CMD_WRITE: begin
                for (int b = 7; b >= 0; b--) begin
                    sda_q = c.wdata[b]; push_phase('0, 1'b0, 1'b0);
                    scl_q = 1'b1;       push_phase('0, 1'b0, 1'b0);
                    scl_q = 1'b0;       push_phase('0, 1'b0, b == 0);
                end
            end
            CMD_READ: begin
                drive_q = 1'b0;  push_phase('0, 1'b0, 1'b0);
                for (int b = 7; b >= 0; b--) begin
                    scl_q = 1'b0; push_phase('0, 1'b0, 1'b0);
                    scl_q = 1'b1; push_phase('0, 1'b0, 1'b0);
                    rx = {rx[6:0], c.line_bits[b]};
                end
                // ACK is driven even on the final byte
                drive_q = 1'b1;  push_phase('0, 1'b0, 1'b0);
                scl_q = 1'b0;    push_phase('0, 1'b0, 1'b0);
                sda_q = 1'b0;    push_phase('0, 1'b0, 1'b0);
                scl_q = 1'b1;    push_phase('0, 1'b0, 1'b0);
                scl_q = 1'b0;    push_phase(rx, 1'b0, 1'b1);
            end
            CMD_CHECK: begin
                sda_q = 1'b1;    push_phase('0, 1'b0, 1'b0);
                scl_q = 1'b1;    push_phase('0, 1'b0, 1'b0);
                drive_q = 1'b0;  push_phase('0, 1'b0, 1'b0);
                drive_q = 1'b1;  push_phase('0, 1'b0, 1'b0);
                scl_q = 1'b0;    push_phase('0, c.line_ack, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h got %0h", $time, name, exp_v, act_v);
        end
    endfunction

    // Sample both sides: predict on each accepted command, check each phase word
    always @(posedge i_clk) begin : mon
        t_pin_phase p;
        s_word_taken = i_rst_n && s_tvalid && s_tready;
        if (s_word_taken) begin
            t_i2c_cmd c;
            c.cmd = s_tuser;
            c.wdata = s_tdata[7:0];
            c.line_bits = s_tdata[15:8];
            c.line_ack = s_tdata[16];
            c.drain = 1'b0;
            n_taken[s_tuser]++;
            predict_pin_phases(c);
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            n_phases_seen++;
            if (exp_phases.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected phase word, expected none got %0h last %0b",
                         $time, m_tdata, m_tlast);
            end else begin
                p = exp_phases.pop_front();
                cmp_field("scl_level", 8'(p.scl), 8'(m_tdata[0]));
                cmp_field("sda_level", 8'(p.sda), 8'(m_tdata[1]));
                cmp_field("sda_enable", 8'(p.sda_en), 8'(m_tdata[2]));
                cmp_field("read_data", p.rd_byte, m_tdata[10:3]);
                cmp_field("ack_seen", 8'(p.ack), 8'(m_tdata[11]));
                cmp_field("last_phase", 8'(p.last), 8'(m_tlast));
            end
        end
    end

    // Feed commands in bursts with random gaps
    always @(negedge i_clk) begin : drv
        t_i2c_cmd c;
        if (i_rst_n && (!s_tvalid || s_word_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() == 0 || (cmd_q[0].drain && exp_phases.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                c = cmd_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {7'b0, c.line_ack, c.line_bits, c.wdata};
                s_tuser <= c.cmd;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
        end
    end

    // Output side backpressure: modes that change every so often
    always @(negedge i_clk) begin : rcv
        logic rdy;
        rdy = 1'b1;
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(40, 160);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            1: rdy = ($urandom_range(0, 3) != 0);
            2: rdy = ($urandom_range(0, 3) == 0);
            3: begin
                if (rx_stall_left > 0) begin
                    rx_stall_left--;
                    rdy = 1'b0;
                end else begin
                    rx_stall_left = $urandom_range(0, 15);
                end
            end
            default: ;
        endcase
        m_tready <= rdy;
    end

    // End the run if nothing useful moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready && exp_phases.size() != 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout at %0t with %0d phases pending", $time, exp_phases.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin : stim
        logic [7:0] addr;
        int n_data;
        foreach (n_taken[k])
            n_taken[k] = 0;

        // Directed: extremes, every command, reserved codes, drive re-enabled
        // on either latch level, ACK driven on the last read byte
        add_cmd(CMD_START, 8'($urandom()), 8'($urandom()), 1'($urandom()), 1'b0);
        add_cmd(CMD_WRITE, 8'h00, 8'hFF, 1'b1, 1'b0);
        add_cmd(CMD_CHECK, 8'hFF, 8'hFF, 1'b0, 1'b0);
        add_cmd(CMD_READ, 8'hFF, 8'h00, 1'b1, 1'b0);
        add_cmd(CMD_WRITE, 8'hFF, 8'h00, 1'b0, 1'b0);
        add_cmd(CMD_READ, 8'h00, 8'hFF, 1'b0, 1'b0);
        add_cmd(CMD_CHECK, 8'h00, 8'h00, 1'b1, 1'b0);
        add_cmd(CMD_WRITE, 8'hA5, 8'h3C, 1'b1, 1'b0);
        add_cmd(CMD_CHECK, 8'h5A, 8'hC3, 1'b0, 1'b0);
        add_cmd(CMD_READ, 8'h0F, 8'h5A, 1'b1, 1'b0);
        add_cmd(CMD_STOP, 8'($urandom()), 8'($urandom()), 1'($urandom()), 1'b0);
        add_cmd(CMD_RSVD_LO, 8'hFF, 8'hFF, 1'b1, 1'b0);
        add_cmd(CMD_RSVD_LO + 3'd1, 8'h00, 8'h00, 1'b0, 1'b0);
        add_cmd(CMD_RSVD_HI, 8'($urandom()), 8'($urandom()), 1'($urandom()), 1'b0);
        add_cmd(CMD_START, 8'($urandom()), 8'($urandom()), 1'($urandom()), 1'b1);
        add_cmd(CMD_WRITE, 8'h80, 8'($urandom()), 1'($urandom()), 1'b0);
        add_cmd(CMD_WRITE, 8'h01, 8'($urandom()), 1'($urandom()), 1'b0);
        add_cmd(CMD_START, 8'($urandom()), 8'($urandom()), 1'($urandom()), 1'b0);
        add_cmd(CMD_STOP, 8'($urandom()), 8'($urandom()), 1'($urandom()), 1'b0);
        add_cmd(CMD_STOP, 8'($urandom()), 8'($urandom()), 1'($urandom()), 1'b0);

        // Random: mostly well-formed transfers, some noise
        while (n_real_cmds < NUM_CMDS_WANTED) begin
            if ($urandom_range(0, 9) < 8) begin
                addr = 8'($urandom());
                add_cmd(CMD_START, 8'($urandom()), 8'($urandom()), 1'($urandom()),
                        $urandom_range(0, 5) == 0);
                add_cmd(CMD_WRITE, addr, 8'($urandom()), 1'($urandom()), 1'b0);
                add_cmd(CMD_CHECK, 8'($urandom()), 8'($urandom()),
                        $urandom_range(0, 3) == 0, 1'b0);
                n_data = $urandom_range(1, 4);
                for (int i = 0; i < n_data; i++) begin
                    if (addr[0]) begin
                        add_cmd(CMD_READ, 8'($urandom()), 8'($urandom()),
                                1'($urandom()), 1'b0);
                    end else begin
                        add_cmd(CMD_WRITE, 8'($urandom()), 8'($urandom()),
                                1'($urandom()), 1'b0);
                        add_cmd(CMD_CHECK, 8'($urandom()), 8'($urandom()),
                                $urandom_range(0, 3) == 0, 1'b0);
                    end
                end
                add_cmd(CMD_STOP, 8'($urandom()), 8'($urandom()), 1'($urandom()), 1'b0);
            end else begin
                n_data = $urandom_range(1, 3);
                for (int i = 0; i < n_data; i++)
                    add_cmd(3'($urandom_range(0, 7)), 8'($urandom()), 8'($urandom()),
                            1'($urandom()), 1'b0);
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (cmd_q.size() == 0 && !s_tvalid);
        wait (exp_phases.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d start, %0d stop, %0d write, %0d read, %0d check commands",
                 n_taken[CMD_START], n_taken[CMD_STOP], n_taken[CMD_WRITE],
                 n_taken[CMD_READ], n_taken[CMD_CHECK]);
        $display("plus %0d reserved codes dropped; %0d phase words checked",
                 n_taken[5] + n_taken[6] + n_taken[7], n_phases_seen);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* i2c_master_byte_engine.f */
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_shift.sv
rtl/i2c_master_byte_engine.sv
test/tb_i2c_master_byte_engine.sv
